>>> sv/stdp_synapse_weight_update_macros.svh
// Assertion helpers used by the checker file stdpw_check.sv.
`ifndef STDP_SYNAPSE_WEIGHT_UPDATE_MACROS_SVH
`define STDP_SYNAPSE_WEIGHT_UPDATE_MACROS_SVH

// Clocked check, off while reset is high.
`define STDPW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define STDPW_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/stdpw_pkg.sv
`timescale 1ns / 1ps
package stdpw_pkg;

  localparam int REG_BITS     = 16;
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_GAIN_POT   = 3'd0,
    REG_GAIN_DEP   = 3'd1,
    REG_TAU_POT    = 3'd2,
    REG_TAU_DEP    = 3'd3,
    REG_MAX_WEIGHT = 3'd4,
    REG_MIN_WEIGHT = 3'd5
  } reg_idx_t;

  localparam logic [REG_BITS-1:0] GAIN_POT_RESET   = 16'd410;
  localparam logic [REG_BITS-1:0] GAIN_DEP_RESET   = 16'd430;
  localparam logic [REG_BITS-1:0] TAU_POT_RESET    = 16'd20;
  localparam logic [REG_BITS-1:0] TAU_DEP_RESET    = 16'd20;
  localparam logic [REG_BITS-1:0] MAX_WEIGHT_RESET = 16'd4096;
  localparam logic [REG_BITS-1:0] MIN_WEIGHT_RESET = 16'd0;

  // dt/tau in Q4.16 stays below 12.0, so 20 bits
  localparam int X_BITS        = 20;
  localparam int FRAC_BITS     = 32;
  localparam int E_BITS        = 16;
  localparam int SERIES_TERMS  = 12;
  localparam int SQUARE_STEPS  = 4;
  localparam logic [E_BITS-1:0] E_ONE_SAT = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_BITS   = 1;

  typedef struct packed {
    logic cmd;
    logic skip;
  } item_ctl_t;

  typedef struct packed {
    logic [REG_BITS-1:0] gain_pot;
    logic [REG_BITS-1:0] gain_dep;
    logic [REG_BITS-1:0] tau_pot;
    logic [REG_BITS-1:0] tau_dep;
    logic [REG_BITS-1:0] max_w;
    logic [REG_BITS-1:0] min_w;
  } cfg_t;

endpackage

>>> sv/stdpw_div.sv
`timescale 1ns / 1ps
module stdpw_div
  import stdpw_pkg::*;
#(
  parameter int Q_BITS = 16,
  parameter int D_BITS = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D_BITS-1:0] in_rem,
  input  logic [Q_BITS-1:0] in_low,
  input  logic [D_BITS-1:0] in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_BITS-1:0] out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [1:Q_BITS];
  logic [D_BITS-1:0] rem  [1:Q_BITS];
  logic [Q_BITS-1:0] low  [1:Q_BITS];
  logic [Q_BITS-1:0] quo  [1:Q_BITS];
  logic [D_BITS-1:0] den  [1:Q_BITS];
  logic [SIDE_W-1:0] side [1:Q_BITS];

  for (genvar g = 1; g <= Q_BITS; g++) begin : g_stage
    logic              s_vld;
    logic [D_BITS-1:0] s_rem;
    logic [Q_BITS-1:0] s_low;
    logic [Q_BITS-1:0] s_quo;
    logic [D_BITS-1:0] s_den;
    logic [SIDE_W-1:0] s_side;
    logic [D_BITS:0]   trial;
    logic              ge;

    if (g == 1) begin : g_src_in
      assign s_vld  = in_valid;
      assign s_rem  = in_rem;
      assign s_low  = in_low;
      assign s_quo  = '0;
      assign s_den  = in_den;
      assign s_side = in_side;
    end else begin : g_src_prev
      assign s_vld  = vld[g-1];
      assign s_rem  = rem[g-1];
      assign s_low  = low[g-1];
      assign s_quo  = quo[g-1];
      assign s_den  = den[g-1];
      assign s_side = side[g-1];
    end

    // one quotient bit per stage
    assign trial = {s_rem, s_low[Q_BITS-1]};
    assign ge    = trial >= {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= ge ? D_BITS'(trial - {1'b0, s_den}) : D_BITS'(trial);
        low[g]  <= {s_low[Q_BITS-2:0], 1'b0};
        quo[g]  <= {s_quo[Q_BITS-2:0], ge};
        den[g]  <= s_den;
        side[g] <= s_side;
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign out_quo   = quo[Q_BITS];
  assign out_side  = side[Q_BITS];

endmodule

>>> sv/stdpw_decay.sv
`timescale 1ns / 1ps
module stdpw_decay
  import stdpw_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              in_zero,
  input  logic [X_BITS-1:0] in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [E_BITS-1:0] out_e,
  output logic [SIDE_W-1:0] out_side
);

  localparam int TERM_STAGES = 3 * (SERIES_TERMS - 1);
  localparam int LAST        = TERM_STAGES + SQUARE_STEPS;

  typedef struct packed {
    logic                 zero;
    logic                 sat;
    logic [FRAC_BITS-1:0] r;
    logic [FRAC_BITS-1:0] sum;
    logic [FRAC_BITS-1:0] a;
    logic [FRAC_BITS-1:0] b;
    logic [SIDE_W-1:0]    side;
  } dstage_t;

  dstage_t st  [0:LAST];
  logic    vld [0:LAST];

  logic [FRAC_BITS-1:0] r0;
  assign r0 = {in_x, {(FRAC_BITS - X_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // first term is r itself; sum starts at 1 - r
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].zero <= in_zero;
      st[0].sat  <= in_x == '0;
      st[0].r    <= r0;
      st[0].sum  <= '0 - r0;
      st[0].a    <= r0;
      st[0].b    <= '0;
      st[0].side <= in_side;
    end
  end

  for (genvar g = 1; g <= LAST; g++) begin : g_stage
    dstage_t nxt;

    if (g <= TERM_STAGES) begin : g_term
      localparam int ROLE = (g - 1) % 3;
      localparam int N    = (g - 1) / 3 + 2;
      localparam logic [FRAC_BITS-1:0] RECIP = FRAC_BITS'((64'd1 << FRAC_BITS) / N);

      if (ROLE == 0) begin : g_mul
        logic [2*FRAC_BITS-1:0] prod;
        assign prod = {{FRAC_BITS{1'b0}}, st[g-1].a} * {{FRAC_BITS{1'b0}}, st[g-1].r};
        always_comb begin
          nxt   = st[g-1];
          nxt.a = prod[2*FRAC_BITS-1:FRAC_BITS];
        end
      end else if (ROLE == 1) begin : g_recip
        logic [2*FRAC_BITS-1:0] prod;
        assign prod = {{FRAC_BITS{1'b0}}, st[g-1].a} * {{FRAC_BITS{1'b0}}, RECIP};
        always_comb begin
          nxt   = st[g-1];
          nxt.b = prod[2*FRAC_BITS-1:FRAC_BITS];
        end
      end else begin : g_fix
        logic [FRAC_BITS-1:0] back_mul;
        logic [FRAC_BITS-1:0] left;
        logic [FRAC_BITS-1:0] term;
        assign back_mul = st[g-1].b * FRAC_BITS'(N);
        assign left     = st[g-1].a - back_mul;
        // reciprocal estimate is at most one low
        assign term     = (left >= FRAC_BITS'(N)) ? st[g-1].b + 1'b1 : st[g-1].b;
        if (N % 2 == 0) begin : g_add
          always_comb begin
            nxt     = st[g-1];
            nxt.a   = term;
            nxt.sum = st[g-1].sum + term;
          end
        end else begin : g_sub
          always_comb begin
            nxt     = st[g-1];
            nxt.a   = term;
            nxt.sum = st[g-1].sum - term;
          end
        end
      end
    end else begin : g_square
      logic [2*FRAC_BITS-1:0] prod;
      assign prod = {{FRAC_BITS{1'b0}}, st[g-1].sum} * {{FRAC_BITS{1'b0}}, st[g-1].sum};
      always_comb begin
        nxt     = st[g-1];
        nxt.sum = prod[2*FRAC_BITS-1:FRAC_BITS];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st[LAST].zero) begin
        out_e <= '0;
      end else if (st[LAST].sat) begin
        out_e <= E_ONE_SAT;
      end else begin
        out_e <= st[LAST].sum[FRAC_BITS-1:FRAC_BITS-E_BITS];
      end
      out_side <= st[LAST].side;
    end
  end

endmodule

>>> sv/stdpw_front.sv
`timescale 1ns / 1ps
module stdpw_front
  import stdpw_pkg::*;
#(
  parameter int WEIGHT_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   cmd,
  input  logic [TIME_BITS-1:0]   event_time,
  input  logic [TIME_BITS-1:0]   partner_time,
  input  logic                   partner_fired,
  input  logic [WEIGHT_BITS-1:0] weight_in,
  output logic                   q_valid,
  input  logic                   q_pop,
  output item_ctl_t              q_ctl,
  output logic [TIME_BITS-1:0]   q_dt,
  output logic [WEIGHT_BITS-1:0] q_w
);

  item_ctl_t              qctl [0:QUEUE_DEPTH-1];
  logic [TIME_BITS-1:0]   qdt  [0:QUEUE_DEPTH-1];
  logic [WEIGHT_BITS-1:0] qw   [0:QUEUE_DEPTH-1];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  item_ctl_t ctl;
  logic      do_push;
  logic      do_pop;

  // skip when the partner never fired or the event is not later than the partner
  assign ctl.cmd  = cmd;
  assign ctl.skip = !partner_fired || (event_time <= partner_time);

  assign full    = count == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      qctl[wr_ptr] <= ctl;
      qdt[wr_ptr]  <= event_time - partner_time;
      qw[wr_ptr]   <= weight_in;
    end
  end

  assign q_ctl = qctl[rd_ptr];
  assign q_dt  = qdt[rd_ptr];
  assign q_w   = qw[rd_ptr];

endmodule

>>> sv/stdpw_back.sv
`timescale 1ns / 1ps
module stdpw_back
  import stdpw_pkg::*;
#(
  parameter int WEIGHT_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  item_ctl_t              q_ctl,
  input  logic [TIME_BITS-1:0]   q_dt,
  input  logic [WEIGHT_BITS-1:0] q_w,
  output logic                   out_valid,
  output logic [WEIGHT_BITS-1:0] out_weight,
  output logic                   out_updated
);

  localparam int XW = ((WEIGHT_BITS > REG_BITS) ? WEIGHT_BITS : REG_BITS) + 1;
  localparam int DW = (TIME_BITS > X_BITS) ? TIME_BITS : X_BITS;
  localparam int S1 = 3 + REG_BITS + WEIGHT_BITS;
  localparam int S2 = 2 + REG_BITS + WEIGHT_BITS;
  localparam int S3 = 3 + REG_BITS + WEIGHT_BITS;
  localparam int LOW_BITS = X_BITS - REG_BITS;

  // issue stage
  logic                   a_v;
  logic                   a_cmd;
  logic                   a_skip;
  logic [TIME_BITS-1:0]   a_dt;
  logic [WEIGHT_BITS-1:0] a_w;
  logic [REG_BITS-1:0]    a_tau;
  logic [REG_BITS-1:0]    a_gain;

  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd  <= q_ctl.cmd;
      a_skip <= q_ctl.skip;
      a_dt   <= q_dt;
      a_w    <= q_w;
      a_tau  <= q_ctl.cmd ? cfg.tau_dep : cfg.tau_pot;
      a_gain <= q_ctl.cmd ? cfg.gain_dep : cfg.gain_pot;
    end
  end

  logic [DW-1:0]     dt_x;
  logic [X_BITS-1:0] tau12;
  logic              zero;

  assign dt_x  = DW'(a_dt);
  assign tau12 = (X_BITS'(a_tau) << 3) + (X_BITS'(a_tau) << 2);
  assign zero  = (a_tau == '0) || (dt_x >= DW'(tau12));

  // dt * 2^16 / tau
  logic              d1_v;
  logic [X_BITS-1:0] d1_q;
  logic [S1-1:0]     d1_side;

  stdpw_div #(
    .Q_BITS (X_BITS),
    .D_BITS (REG_BITS),
    .SIDE_W (S1)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_v),
    .in_rem    (dt_x[X_BITS-1:LOW_BITS]),
    .in_low    ({dt_x[LOW_BITS-1:0], {REG_BITS{1'b0}}}),
    .in_den    (a_tau),
    .in_side   ({a_cmd, a_skip, zero, a_gain, a_w}),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_side  (d1_side)
  );

  logic                   d1_cmd;
  logic                   d1_skip;
  logic                   d1_zero;
  logic [REG_BITS-1:0]    d1_gain;
  logic [WEIGHT_BITS-1:0] d1_w;

  assign {d1_cmd, d1_skip, d1_zero, d1_gain, d1_w} = d1_side;

  logic              e_v;
  logic [E_BITS-1:0] e_val;
  logic [S2-1:0]     e_side;

  stdpw_decay #(
    .SIDE_W (S2)
  ) u_decay (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_v),
    .in_zero   (d1_zero),
    .in_x      (d1_q),
    .in_side   ({d1_cmd, d1_skip, d1_gain, d1_w}),
    .out_valid (e_v),
    .out_e     (e_val),
    .out_side  (e_side)
  );

  logic                   e_cmd;
  logic                   e_skip;
  logic [REG_BITS-1:0]    e_gain;
  logic [WEIGHT_BITS-1:0] e_w;
  logic [2*REG_BITS-1:0]  gprod;

  assign {e_cmd, e_skip, e_gain, e_w} = e_side;
  assign gprod = (2*REG_BITS)'(e_gain) * (2*REG_BITS)'(e_val);

  // step = gain * e
  logic                   g_v;
  logic                   g_cmd;
  logic                   g_skip;
  logic [WEIGHT_BITS-1:0] g_w;
  logic [REG_BITS-1:0]    g_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_cmd  <= e_cmd;
      g_skip <= e_skip;
      g_w    <= e_w;
      g_step <= gprod[2*REG_BITS-1:REG_BITS];
    end
  end

  // taper numerator step * (max - w)
  logic                  taper;
  logic [REG_BITS-1:0]   diff;
  logic [2*REG_BITS-1:0] tprod;

  assign taper = !g_cmd && (XW'(g_w) < XW'(cfg.max_w));
  assign diff  = cfg.max_w - REG_BITS'(g_w);
  assign tprod = (2*REG_BITS)'(g_step) * (2*REG_BITS)'(diff);

  logic                   h_v;
  logic                   h_cmd;
  logic                   h_skip;
  logic                   h_taper;
  logic [REG_BITS-1:0]    h_step;
  logic [WEIGHT_BITS-1:0] h_w;
  logic [2*REG_BITS-1:0]  h_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_cmd   <= g_cmd;
      h_skip  <= g_skip;
      h_taper <= taper;
      h_step  <= g_step;
      h_w     <= g_w;
      h_prod  <= taper ? tprod : '0;
    end
  end

  logic                d2_v;
  logic [REG_BITS-1:0] d2_q;
  logic [S3-1:0]       d2_side;

  stdpw_div #(
    .Q_BITS (REG_BITS),
    .D_BITS (REG_BITS),
    .SIDE_W (S3)
  ) u_div_taper (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_v),
    .in_rem    (h_prod[2*REG_BITS-1:REG_BITS]),
    .in_low    (h_prod[REG_BITS-1:0]),
    .in_den    (cfg.max_w),
    .in_side   ({h_cmd, h_skip, h_taper, h_step, h_w}),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_side  (d2_side)
  );

  logic                   f_cmd;
  logic                   f_skip;
  logic                   f_taper;
  logic [REG_BITS-1:0]    f_step;
  logic [WEIGHT_BITS-1:0] f_w;
  logic [XW-1:0]          w_x;
  logic [XW-1:0]          pot_step;
  logic [XW-1:0]          dep_step;
  logic [XW-1:0]          w_new;
  logic [XW-1:0]          w_lo;
  logic [XW-1:0]          w_clamp;

  assign {f_cmd, f_skip, f_taper, f_step, f_w} = d2_side;
  assign w_x      = XW'(f_w);
  assign pot_step = f_taper ? XW'(d2_q) : '0;
  assign dep_step = XW'(f_step);

  always_comb begin
    if (f_cmd) begin
      w_new = (dep_step > w_x) ? '0 : w_x - dep_step;
    end else begin
      w_new = w_x + pot_step;
    end
    w_lo    = (w_new < XW'(cfg.min_w)) ? XW'(cfg.min_w) : w_new;
    w_clamp = (w_lo > XW'(cfg.max_w)) ? XW'(cfg.max_w) : w_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weight  <= f_skip ? f_w : WEIGHT_BITS'(w_clamp);
      out_updated <= !f_skip;
    end
  end

endmodule

>>> sv/stdp_synapse_weight_update.sv
`timescale 1ns / 1ps
// Pair-based STDP weight update, one synapse record per beat.
// Input queue: drive the record with push; it is taken on a clock edge where
// full is low. Result queue: while empty is low the oldest result sits on
// weight_out/updated; pop takes it.
// Configuration: wr_en/wr_index/wr_data write one 16-bit register per cycle.
// Write only while no record is in flight; the block does not enforce this.
// The pipeline length is set by the pipelined dt/tau divider (20 stages),
// the exp series (11 terms of three stages each, four squares) and the
// taper divider (16 stages).
// Throughput: one record per cycle while the back pipeline runs; every stage
// holds a record, and the divider and multiplier stages are not shared.
// Stall: with a result at the end of the back pipeline, a full result queue
// and nobody popping, the back pipeline freezes; the four-entry input queue
// keeps accepting until it fills, then raises full.
// Reset (rst, synchronous) empties both queues, drops everything in flight
// and loads the register defaults.
module stdp_synapse_weight_update
  import stdpw_pkg::*;
#(
  parameter int WEIGHT_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    cmd,
  input  logic [TIME_BITS-1:0]    event_time,
  input  logic [TIME_BITS-1:0]    partner_time,
  input  logic                    partner_fired,
  input  logic [WEIGHT_BITS-1:0]  weight_in,
  output logic                    empty,
  input  logic                    pop,
  output logic [WEIGHT_BITS-1:0]  weight_out,
  output logic                    updated,
  input  logic                    wr_en,
  input  logic [REG_IDX_BITS-1:0] wr_index,
  input  logic [REG_BITS-1:0]     wr_data
);

  localparam logic [REG_BITS-1:0] W_MASK = (WEIGHT_BITS >= REG_BITS) ? {REG_BITS{1'b1}} :
                                           REG_BITS'((32'd1 << WEIGHT_BITS) - 32'd1);

  cfg_t regs;
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_pot <= GAIN_POT_RESET;
      regs.gain_dep <= GAIN_DEP_RESET;
      regs.tau_pot  <= TAU_POT_RESET;
      regs.tau_dep  <= TAU_DEP_RESET;
      regs.max_w    <= MAX_WEIGHT_RESET;
      regs.min_w    <= MIN_WEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_GAIN_POT:   regs.gain_pot <= wr_data;
        REG_GAIN_DEP:   regs.gain_dep <= wr_data;
        REG_TAU_POT:    regs.tau_pot  <= wr_data;
        REG_TAU_DEP:    regs.tau_dep  <= wr_data;
        REG_MAX_WEIGHT: regs.max_w    <= wr_data;
        REG_MIN_WEIGHT: regs.min_w    <= wr_data;
        default: ;
      endcase
    end
  end

  // weights and gains live in the weight format
  assign cfg.gain_pot = regs.gain_pot & W_MASK;
  assign cfg.gain_dep = regs.gain_dep & W_MASK;
  assign cfg.tau_pot  = regs.tau_pot;
  assign cfg.tau_dep  = regs.tau_dep;
  assign cfg.max_w    = regs.max_w & W_MASK;
  assign cfg.min_w    = regs.min_w & W_MASK;

  logic                   q_valid;
  logic                   q_pop;
  item_ctl_t              q_ctl;
  logic [TIME_BITS-1:0]   q_dt;
  logic [WEIGHT_BITS-1:0] q_w;

  stdpw_front #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .event_time    (event_time),
    .partner_time  (partner_time),
    .partner_fired (partner_fired),
    .weight_in     (weight_in),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_ctl         (q_ctl),
    .q_dt          (q_dt),
    .q_w           (q_w)
  );

  logic                   en;
  logic                   b_v;
  logic [WEIGHT_BITS-1:0] b_w;
  logic                   b_upd;

  stdpw_back #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_ctl       (q_ctl),
    .q_dt        (q_dt),
    .q_w         (q_w),
    .out_valid   (b_v),
    .out_weight  (b_w),
    .out_updated (b_upd)
  );

  // result queue
  logic [WEIGHT_BITS-1:0] ow [0:OUT_DEPTH-1];
  logic                   ou [0:OUT_DEPTH-1];
  logic [OPTR_BITS-1:0]   o_wr;
  logic [OPTR_BITS-1:0]   o_rd;
  logic [OPTR_BITS:0]     o_cnt;
  logic                   o_full;
  logic                   o_push;
  logic                   o_pop;

  assign empty  = o_cnt == '0;
  assign o_full = o_cnt == (OPTR_BITS + 1)'(OUT_DEPTH);
  assign o_pop  = pop && !empty;
  // hold the back pipeline only when its last beat has nowhere to go
  assign en     = !b_v || !o_full || o_pop;
  assign o_push = en && b_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= '0;
      o_rd  <= '0;
      o_cnt <= '0;
    end else begin
      if (o_push) begin
        o_wr <= o_wr + 1'b1;
      end
      if (o_pop) begin
        o_rd <= o_rd + 1'b1;
      end
      if (o_push && !o_pop) begin
        o_cnt <= o_cnt + 1'b1;
      end else if (o_pop && !o_push) begin
        o_cnt <= o_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      ow[o_wr] <= b_w;
      ou[o_wr] <= b_upd;
    end
  end

  assign weight_out = ow[o_rd];
  assign updated    = ou[o_rd];

endmodule

>>> sv/stdpw_check.sv
`timescale 1ns / 1ps
`include "stdp_synapse_weight_update_macros.svh"
module stdpw_check
  import stdpw_pkg::*;
#(
  parameter int WEIGHT_BITS = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    push,
  input logic                    full,
  input logic                    pop,
  input logic                    empty,
  input logic [WEIGHT_BITS-1:0]  weight_out,
  input logic                    updated,
  input logic                    wr_en,
  input logic [REG_IDX_BITS-1:0] wr_index,
  input logic [REG_BITS-1:0]     wr_data
);

  localparam int CW = ((WEIGHT_BITS > REG_BITS) ? WEIGHT_BITS : REG_BITS) + 1;
  localparam logic [REG_BITS-1:0] W_MASK = (WEIGHT_BITS >= REG_BITS) ? {REG_BITS{1'b1}} :
                                           REG_BITS'((32'd1 << WEIGHT_BITS) - 32'd1);

  logic [REG_BITS-1:0] max_shadow;
  logic [7:0]          pending;
  logic                acc_in;
  logic                acc_out;
  logic                out_ok;
  logic                idle;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;
  assign out_ok  = CW'(weight_out) <= CW'(max_shadow & W_MASK);
  assign idle    = pending == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_shadow <= MAX_WEIGHT_RESET;
      pending    <= '0;
    end else begin
      if (wr_en && (wr_index == REG_MAX_WEIGHT)) begin
        max_shadow <= wr_data;
      end
      pending <= pending + 8'(acc_in) - 8'(acc_out);
    end
  end

  `STDPW_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "queues not empty after reset")
  `STDPW_ASSERT(a_no_phantom, clk, rst, idle |-> empty, "result shown with no record in flight")
  `STDPW_ASSERT(a_upper_bound, clk, rst, (!empty && updated) |-> out_ok, "updated weight above max")
  `STDPW_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(weight_out) && $stable(updated)), "result changed while waiting")

endmodule

bind stdp_synapse_weight_update stdpw_check #(.WEIGHT_BITS(WEIGHT_BITS)) u_check (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .weight_out (weight_out),
  .updated    (updated),
  .wr_en      (wr_en),
  .wr_index   (wr_index),
  .wr_data    (wr_data)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import stdpw_pkg::*;

  localparam int WB = 16;
  localparam int TB = 32;

  typedef struct {
    logic [WB-1:0] weight;
    logic          applied;
  } weight_result_t;

  // Predicts each new weight and checks it against the block's results in order.
  class weight_scoreboard;
    logic [REG_BITS-1:0] gain_pot, gain_dep, tau_pot, tau_dep, max_w, min_w;
    weight_result_t due[$];
    int fails;
    int checked;
    int applied_cnt;

    function new();
      gain_pot = GAIN_POT_RESET;
      gain_dep = GAIN_DEP_RESET;
      tau_pot  = TAU_POT_RESET;
      tau_dep  = TAU_DEP_RESET;
      max_w    = MAX_WEIGHT_RESET;
      min_w    = MIN_WEIGHT_RESET;
      fails = 0;
      checked = 0;
      applied_cnt = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [REG_BITS-1:0] val);
      case (idx)
        REG_GAIN_POT:   gain_pot = val;
        REG_GAIN_DEP:   gain_dep = val;
        REG_TAU_POT:    tau_pot  = val;
        REG_TAU_DEP:    tau_dep  = val;
        REG_MAX_WEIGHT: max_w    = val;
        REG_MIN_WEIGHT: min_w    = val;
        default: ;
      endcase
    endfunction

    // exp(-dt/tau) in Q0.16 through a truncated series and four squarings
    function logic [15:0] decay(logic [63:0] dt, logic [63:0] tau);
      logic [63:0]  x, r, term, acc;
      logic [127:0] prod;
      if (tau == 0) return 16'd0;
      if (dt >= tau * 12) return 16'd0;
      x = (dt << 16) / tau;
      if (x == 0) return 16'hFFFF;
      r = x << 12;
      term = 64'd1 << 32;
      acc = term;
      for (int n = 1; n <= 12; n++) begin
        prod = 128'(term) * 128'(r);
        term = 64'(prod >> 32) / 64'(n);
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      for (int n = 0; n < 4; n++) begin
        prod = 128'(acc) * 128'(acc);
        acc = 64'(prod >> 32);
      end
      acc = acc >> 16;
      return (acc > 65535) ? 16'hFFFF : acc[15:0];
    endfunction

    function void note(logic c, logic [TB-1:0] t_ev, logic [TB-1:0] t_pa, logic fired,
                       logic [WB-1:0] w);
      weight_result_t res;
      logic [63:0] dt, step, w_new, wmax, wmin, wx;
      wmax = 64'(max_w);
      wmin = 64'(min_w);
      wx = 64'(w);
      if (!fired || t_ev <= t_pa) begin
        res.weight = w;
        res.applied = 1'b0;
      end else begin
        dt = 64'(t_ev - t_pa);
        if (c == 1'b0) begin
          step = (64'(gain_pot) * 64'(decay(dt, 64'(tau_pot)))) >> 16;
          if (wx >= wmax) step = 0;
          else step = (step * (wmax - wx)) / wmax;
          w_new = wx + step;
        end else begin
          step = (64'(gain_dep) * 64'(decay(dt, 64'(tau_dep)))) >> 16;
          w_new = (step > wx) ? 64'd0 : wx - step;
        end
        if (w_new < wmin) w_new = wmin;
        if (w_new > wmax) w_new = wmax;
        res.weight = w_new[WB-1:0];
        res.applied = 1'b1;
      end
      due.push_back(res);
    endfunction

    function void check(logic [WB-1:0] w, logic upd);
      weight_result_t exp_r;
      checked++;
      if (due.size() == 0) begin
        $error("result beat with no expected weight: weight_out=%0d updated=%0d", w, upd);
        fails++;
        return;
      end
      exp_r = due.pop_front();
      if (upd) applied_cnt++;
      if (w !== exp_r.weight) begin
        $error("weight_out: expected %0d, got %0d", exp_r.weight, w);
        fails++;
      end
      if (upd !== exp_r.applied) begin
        $error("updated: expected %0d, got %0d", exp_r.applied, upd);
        fails++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic cmd = 1'b0;
  logic [TB-1:0] event_time = '0;
  logic [TB-1:0] partner_time = '0;
  logic partner_fired = 1'b0;
  logic [WB-1:0] weight_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic [WB-1:0] weight_out;
  logic updated;
  logic wr_en = 1'b0;
  logic [REG_IDX_BITS-1:0] wr_index = '0;
  logic [REG_BITS-1:0] wr_data = '0;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int sent = 0;

  weight_scoreboard sb = new();

  stdp_synapse_weight_update #(.WEIGHT_BITS(WB), .TIME_BITS(TB)) u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .event_time(event_time), .partner_time(partner_time),
    .partner_fired(partner_fired), .weight_in(weight_in), .empty(empty),
    .pop(pop), .weight_out(weight_out), .updated(updated), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data)
  );

  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: random pops, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 400;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note(cmd, event_time, partner_time, partner_fired, weight_in);
        sent++;
      end
      if (pop && !empty) sb.check(weight_out, updated);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [REG_BITS-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_cfg(logic [15:0] gp, logic [15:0] gd, logic [15:0] tp,
                          logic [15:0] td, logic [15:0] mx, logic [15:0] mn);
    write_reg(REG_GAIN_POT, gp);
    write_reg(REG_GAIN_DEP, gd);
    write_reg(REG_TAU_POT, tp);
    write_reg(REG_TAU_DEP, td);
    write_reg(REG_MAX_WEIGHT, mx);
    write_reg(REG_MIN_WEIGHT, mn);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer(logic c, logic [TB-1:0] te, logic [TB-1:0] tp, logic f,
                       logic [WB-1:0] w);
    while (!calm && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    event_time <= te;
    partner_time <= tp;
    partner_fired <= f;
    weight_in <= w;
    do @(posedge clk); while (full);
  endtask

  // Hold until every expected beat is back, then let the pipeline go quiet.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_item();
    logic c;
    logic [TB-1:0] tp, dt;
    logic [WB-1:0] w;
    logic [15:0] tau;
    int kind;
    c = 1'($urandom_range(1));
    tau = c ? sb.tau_dep : sb.tau_pot;
    tp = $urandom();
    kind = $urandom_range(99);
    if (kind < 75) dt = $urandom_range(13 * tau, 1);
    else if (kind < 85) dt = $urandom();
    else dt = 0;
    if ($urandom_range(9) < 2) w = WB'(sb.max_w - WB'($urandom_range(3)));
    else w = WB'($urandom());
    offer(c, tp + dt, tp, $urandom_range(19) != 0, w);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, edge times, special cases
    offer(1'b0, 32'd100, 32'd50, 1'b0, 16'd1000);
    offer(1'b1, 32'd100, 32'd100, 1'b1, 16'd1000);
    offer(1'b0, 32'd10, 32'd99, 1'b1, 16'd1000);
    offer(1'b0, 32'hFFFFFFFF, 32'd0, 1'b1, 16'd2000);
    offer(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, 16'hFFFF);
    offer(1'b0, 32'd1, 32'd0, 1'b1, 16'd0);
    offer(1'b1, 32'd1, 32'd0, 1'b1, 16'd0);
    offer(1'b0, 32'd240, 32'd0, 1'b1, 16'd100);
    offer(1'b0, 32'd239, 32'd0, 1'b1, 16'd100);
    offer(1'b0, 32'd5, 32'd0, 1'b1, 16'd4096);
    offer(1'b0, 32'd5, 32'd0, 1'b1, 16'hFFFF);
    offer(1'b1, 32'd5, 32'd0, 1'b1, 16'd200);
    offer(1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b1, 16'h8000);
    offer(1'b0, 32'h55555555, 32'h2AAAAAAA, 1'b1, 16'h5555);
    drain();

    // extremes: widest gains, shortest tau, full-scale max
    load_cfg(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd0);
    offer(1'b0, 32'd1, 32'd0, 1'b1, 16'd0);
    offer(1'b1, 32'd1, 32'd0, 1'b1, 16'hFFFF);
    offer(1'b0, 32'd12, 32'd0, 1'b1, 16'd5);
    repeat (150) random_item();
    drain();

    // zero gains, longest tau, a max of one
    load_cfg(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0);
    repeat (120) random_item();
    drain();

    // min above max: max wins; also fill the block under a stalled receiver
    load_cfg(16'd1234, 16'hFFFF, 16'd300, 16'd2, 16'd2000, 16'd3000);
    calm <= 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (150) random_item();
    calm <= 1'b0;
    repeat (50) random_item();
    drain();

    load_cfg(16'd4000, 16'd3000, 16'd50, 16'd7, 16'd8192, 16'd1000);
    repeat (150) random_item();
    calm <= 1'b1;
    repeat (100) random_item();
    calm <= 1'b0;
    drain();

    load_cfg(GAIN_POT_RESET, GAIN_DEP_RESET, 16'd20, 16'd20, 16'd4096, 16'd0);
    repeat (100) random_item();
    drain();

    $display("covered %0d synapse beats over six register settings", sent);
    $display("%0d results checked, %0d with an applied update", sb.checked,
             sb.applied_cnt);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
